[src/brb_pkg.sv]
// Shared types and constants for the chunked circular byte FIFO.
`timescale 1ns / 1ps

package brb_pkg;

   // Fixed field widths of the command and result ports
   localparam int CAP_W  = 11;
   localparam int CMD_W  = 3;
   localparam int LEN_W  = 4;
   localparam int DATA_W = 64;
   localparam int STAT_W = 2;
   localparam int IDX_W  = 3;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SKIP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO_LEN = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_ROOM  = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_TAIL
   } state_type;

   // Configuration as seen by the sequencer
   typedef struct packed {
      logic             clear;
      logic [CAP_W-1:0] capacity;
   } cfg_type;

endpackage

[src/brb_store.sv]
// Byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module brb_store
   import brb_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/brb_ctrl.sv]
// Command sequencer: pointers, fill count, byte-serial store access, result.
`timescale 1ns / 1ps

module brb_ctrl
   import brb_pkg::*;
#(
   parameter int DEPTH     = 1024,
   parameter int MAX_CHUNK = 8,
   localparam int AW       = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [LEN_W-1:0]  req_length,
   input  logic [DATA_W-1:0] req_write_bytes,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [7:0]        mem_wr_data,
   output logic              mem_rd_en,
   output logic [AW-1:0]     mem_rd_addr,
   input  logic [7:0]        mem_rd_data,
   output logic              rsp_strobe,
   output logic [STAT_W-1:0] rsp_status,
   output logic [DATA_W-1:0] rsp_read_bytes,
   output logic [CAP_W-1:0]  rsp_fill_level,
   output logic              rsp_is_empty,
   output logic              rsp_is_full
);

   localparam int PW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

   // Step a position by one, wrapping at the capacity in use
   function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                             input logic [CAP_W-1:0] cap);
      logic [PW-1:0] nxt;
      nxt = PW'(pos) + PW'(1);
      return (nxt >= PW'(cap)) ? '0 : AW'(nxt);
   endfunction

   // Control state
   state_type          state_ff, state_in;
   logic [AW-1:0]      wr_pos_ff, wr_pos_in;
   logic [AW-1:0]      rd_pos_ff, rd_pos_in;
   logic [AW-1:0]      scan_ff, scan_in;
   logic [CAP_W-1:0]   held_ff, held_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               cap_valid_ff, cap_valid_in;
   logic               strobe_ff, strobe_in;

   // Payload state
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [DATA_W-1:0]  wdata_ff, wdata_in;
   logic [IDX_W-1:0]   cap_idx_ff, cap_idx_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [DATA_W-1:0]  rdata_ff, rdata_in;
   logic [CAP_W-1:0]   fill_ff, fill_in;
   logic               empty_ff, empty_in;
   logic               full_ff, full_in;

   logic [LEN_W-1:0]   len_sat;
   logic [CAP_W-1:0]   room;
   logic               last_byte;
   logic [AW-1:0]      scan_next;
   logic               finish;

   assign busy      = (state_ff != S_IDLE);
   assign len_sat   = (req_length > LEN_W'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : req_length;
   assign room      = cfg.capacity - held_ff;
   assign last_byte = ({1'b0, idx_ff} == (len_ff - LEN_W'(1)));
   assign scan_next = advance(scan_ff, cfg.capacity);

   // Next state and store access
   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      scan_in      = scan_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      cap_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      wdata_in     = wdata_ff;
      cap_idx_in   = idx_ff;
      status_in    = status_ff;
      rdata_in     = rdata_ff;
      finish       = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = scan_ff;
      mem_wr_data  = wdata_ff[{idx_ff, 3'b000} +: 8];
      mem_rd_en    = 1'b0;
      mem_rd_addr  = scan_ff;

      // Read data lands in the cycle after its address
      if (cap_valid_ff) begin
         rdata_in[{cap_idx_ff, 3'b000} +: 8] = mem_rd_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_cmd;
               len_in    = len_sat;
               wdata_in  = req_write_bytes;
               rdata_in  = '0;
               idx_in    = '0;
               status_in = STAT_OK;
               priority if ((req_cmd <= CMD_PEEK) && (len_sat == '0)) begin
                  status_in = STAT_ZERO_LEN;
                  finish    = 1'b1;
               end else if (req_cmd == CMD_WRITE) begin
                  if (CAP_W'(len_sat) > room) begin
                     status_in = STAT_NO_ROOM;
                     finish    = 1'b1;
                  end else begin
                     scan_in  = wr_pos_ff;
                     state_in = S_WRITE;
                  end
               end else if (req_cmd <= CMD_PEEK) begin
                  if (held_ff < CAP_W'(len_sat)) begin
                     status_in = STAT_NO_ROOM;
                     finish    = 1'b1;
                  end else begin
                     scan_in  = rd_pos_ff;
                     state_in = S_READ;
                  end
               end else if (req_cmd == CMD_CLEAR) begin
                  wr_pos_in = '0;
                  rd_pos_in = '0;
                  held_in   = '0;
                  finish    = 1'b1;
               end else begin
                  // unknown command: no operation
                  finish = 1'b1;
               end
            end
         end
         S_WRITE: begin
            mem_wr_en = 1'b1;
            scan_in   = scan_next;
            idx_in    = idx_ff + IDX_W'(1);
            if (last_byte) begin
               wr_pos_in = scan_next;
               held_in   = held_ff + CAP_W'(len_ff);
               finish    = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_READ: begin
            mem_rd_en    = (cmd_ff != CMD_SKIP);
            cap_valid_in = (cmd_ff != CMD_SKIP);
            scan_in      = scan_next;
            idx_in       = idx_ff + IDX_W'(1);
            if (last_byte) begin
               if (cmd_ff != CMD_PEEK) begin
                  rd_pos_in = scan_next;
                  held_in   = held_ff - CAP_W'(len_ff);
               end
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            // last read byte is captured at the end of this cycle
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Capacity write empties the queue; the user must write it only while idle, as the block does not enforce it
      if (cfg.clear) begin
         wr_pos_in = '0;
         rd_pos_in = '0;
         held_in   = '0;
      end

      strobe_in = finish;
      fill_in   = held_in;
      empty_in  = (held_in == '0);
      full_in   = (held_in == cfg.capacity);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         scan_ff      <= '0;
         held_ff      <= '0;
         idx_ff       <= '0;
         cap_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         scan_ff      <= scan_in;
         held_ff      <= held_in;
         idx_ff       <= idx_in;
         cap_valid_ff <= cap_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   // Payload registers; status is set on the command transfer and held
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      len_ff     <= len_in;
      wdata_ff   <= wdata_in;
      cap_idx_ff <= cap_idx_in;
      rdata_ff   <= rdata_in;
      status_ff  <= status_in;
      if (finish) begin
         fill_ff   <= fill_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_bytes = rdata_ff;
   assign rsp_fill_level = fill_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_is_full    = full_ff;

endmodule

[src/byte_ring_buffer_chunked.sv]
// Top level of the chunked circular byte FIFO: capacity register, sequencer, store.
//
//   channel   ports                      transfer
//   command   start/busy, req_*          start high while busy low
//   result    rsp_strobe, rsp_*          every cycle rsp_strobe is high
//   config    csr_write_enable/data      every cycle csr_write_enable is high
//
// The result strobe is high in the cycle after the last busy cycle.
// Write of n bytes: one byte per cycle on the store write port while busy.
// Read, peek, skip of n bytes: busy through S_READ, then S_TAIL for the read port latency.
// Clear, unknown, zero-length and refused commands: not busy, result next cycle.
// Reset empties the queue and sets capacity to min(1024, DEPTH); no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps

module byte_ring_buffer_chunked
   import brb_pkg::*;
#(
   parameter int DEPTH     = 1024,
   parameter int MAX_CHUNK = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [LEN_W-1:0]  req_length,
   input  logic [DATA_W-1:0] req_write_bytes,
   output logic              rsp_strobe,
   output logic [STAT_W-1:0] rsp_status,
   output logic [DATA_W-1:0] rsp_read_bytes,
   output logic [CAP_W-1:0]  rsp_fill_level,
   output logic              rsp_is_empty,
   output logic              rsp_is_full,
   input  logic              csr_write_enable,
   input  logic [CAP_W-1:0]  csr_write_data
);

   localparam int AW        = $clog2(DEPTH);
   localparam int CAP_RESET = (DEPTH < 1024) ? DEPTH : 1024;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   cfg_type          cfg;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [7:0]       mem_rd_data;

   // Capacity register, clamped to 1..DEPTH
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write_enable) begin
         priority if (csr_write_data == '0) begin
            capacity_in = CAP_W'(1);
         end else if (32'(csr_write_data) > DEPTH) begin
            capacity_in = CAP_W'(DEPTH);
         end else begin
            capacity_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RESET);
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign cfg.clear    = csr_write_enable;
   assign cfg.capacity = capacity_ff;

   brb_ctrl #(
      .DEPTH     (DEPTH),
      .MAX_CHUNK (MAX_CHUNK)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_length      (req_length),
      .req_write_bytes (req_write_bytes),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_read_bytes  (rsp_read_bytes),
      .rsp_fill_level  (rsp_fill_level),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   brb_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[tb/tb_byte_ring_buffer_chunked.sv]
// Self-checking testbench for the chunked circular byte FIFO.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_chunked
   import brb_pkg::*;
();

   localparam int FIFO_DEPTH   = 1024;
   localparam int FIFO_CHUNK   = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;

   // Command codes with no function in the block
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_bytes;
      logic [CAP_W-1:0]  fill_level;
      logic              is_empty;
      logic              is_full;
   } fifo_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CMD_W-1:0]  req_cmd = CMD_CLEAR;
   logic [LEN_W-1:0]  req_length = '0;
   logic [DATA_W-1:0] req_write_bytes = '0;
   logic              rsp_strobe;
   logic [STAT_W-1:0] rsp_status;
   logic [DATA_W-1:0] rsp_read_bytes;
   logic [CAP_W-1:0]  rsp_fill_level;
   logic              rsp_is_empty;
   logic              rsp_is_full;
   logic              csr_write_enable = 1'b0;
   logic [CAP_W-1:0]  csr_write_data = '0;

   // Shadow FIFO state
   logic [7:0]  shadow_store [0:FIFO_DEPTH-1];
   int unsigned shadow_wpos = 0;
   int unsigned shadow_rpos = 0;
   int unsigned shadow_count = 0;
   int unsigned shadow_cap = FIFO_DEPTH;

   fifo_result_type pending_results [$];
   int          mismatch_count = 0;
   int          idle_pct = 31;
   int          random_sent = 0;
   logic        fill_mode = 1'b1;

   byte_ring_buffer_chunked dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_length       (req_length),
      .req_write_bytes  (req_write_bytes),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_read_bytes   (rsp_read_bytes),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   function automatic int unsigned next_pos(int unsigned pos);
      return (pos + 1 >= shadow_cap) ? 0 : pos + 1;
   endfunction

   // Apply one command to the shadow FIFO and return the result it gives
   function automatic fifo_result_type fifo_apply(logic [CMD_W-1:0] cmd,
                                                  logic [LEN_W-1:0] len,
                                                  logic [DATA_W-1:0] wdata);
      fifo_result_type res;
      int unsigned  n;
      int unsigned  pos;
      int           i;
      n = (len > FIFO_CHUNK) ? FIFO_CHUNK : 32'(len);
      res.status = STAT_OK;
      res.read_bytes = '0;
      case (cmd)
         CMD_WRITE, CMD_READ, CMD_SKIP, CMD_PEEK: begin
            if (n == 0) begin
               res.status = STAT_ZERO_LEN;
            end else if (cmd == CMD_WRITE) begin
               if (n > shadow_cap - shadow_count) begin
                  res.status = STAT_NO_ROOM;
               end else begin
                  for (i = 0; i < n; i++) begin
                     shadow_store[shadow_wpos] = wdata[8*i +: 8];
                     shadow_wpos = next_pos(shadow_wpos);
                  end
                  shadow_count += n;
               end
            end else if (shadow_count < n) begin
               res.status = STAT_NO_ROOM;
            end else begin
               pos = shadow_rpos;
               for (i = 0; i < n; i++) begin
                  if (cmd != CMD_SKIP) res.read_bytes[8*i +: 8] = shadow_store[pos];
                  pos = next_pos(pos);
               end
               if (cmd != CMD_PEEK) begin
                  shadow_rpos = pos;
                  shadow_count -= n;
               end
            end
         end
         CMD_CLEAR: begin
            shadow_wpos = 0;
            shadow_rpos = 0;
            shadow_count = 0;
         end
         default: ;
      endcase
      res.fill_level = shadow_count[CAP_W-1:0];
      res.is_empty = (shadow_count == 0);
      res.is_full = (shadow_count == shadow_cap);
      return res;
   endfunction

   // One command transfer; the sender idles each cycle with the current odds
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                               logic [DATA_W-1:0] wdata);
      fifo_result_type res;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_length <= len;
      req_write_bytes <= wdata;
      @(posedge clock);
      while (busy) @(posedge clock);
      res = fifo_apply(cmd, len, wdata);
      pending_results.push_back(res);
      // Steer the random mix between filling and draining
      if (cmd == CMD_CLEAR) fill_mode = 1'b1;
      else if (res.status == STAT_NO_ROOM) fill_mode = (cmd != CMD_WRITE);
   endtask

   // Hold off until every result is in and the block has settled
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_cap = (value == 0) ? 1 : (value > FIFO_DEPTH) ? FIFO_DEPTH : value;
      shadow_wpos = 0;
      shadow_rpos = 0;
      shadow_count = 0;
   endtask

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h actual %h", name, want, got);
      end
   endtask

   // Result checker: every strobe is a transfer
   always @(posedge clock) begin
      fifo_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("result with no command outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("read_bytes", want.read_bytes, rsp_read_bytes);
            check_field("fill_level", want.fill_level, rsp_fill_level);
            check_field("is_empty", want.is_empty, rsp_is_empty);
            check_field("is_full", want.is_full, rsp_is_full);
         end
      end
   end

   task automatic test_empty_after_reset();
      send_command(CMD_PEEK, 4'd1, '0);
      send_command(CMD_READ, 4'd8, '0);
   endtask

   task automatic test_zero_length();
      send_command(CMD_WRITE, 4'd0, '1);
      send_command(CMD_READ, 4'd0, '1);
      send_command(CMD_SKIP, 4'd0, '1);
      send_command(CMD_PEEK, 4'd0, '1);
   endtask

   // Full-width chunks, saturated lengths, peek versus read versus skip
   task automatic test_chunk_extremes();
      send_command(CMD_WRITE, 4'd8, '1);
      send_command(CMD_WRITE, 4'd15, {$urandom, $urandom});
      send_command(CMD_PEEK, 4'd8, '0);
      send_command(CMD_READ, 4'd8, '0);
      send_command(CMD_SKIP, 4'd15, '0);
      send_command(CMD_READ, 4'd1, '0);
   endtask

   task automatic test_unknown_and_clear();
      send_command(CMD_WRITE, 4'd3, {$urandom, $urandom});
      send_command(CMD_UNUSED_LO, 4'd15, '1);
      send_command(CMD_UNUSED_LO + 3'd1, 4'd1, '1);
      send_command(CMD_UNUSED_HI, 4'd8, '1);
      send_command(CMD_CLEAR, 4'd15, '1);
      send_command(CMD_PEEK, 4'd1, '0);
   endtask

   // Capacity clamping, full flag at one byte, wrap-around, clear on write
   task automatic test_capacity_limits();
      write_capacity(11'd0);
      send_command(CMD_WRITE, 4'd1, {$urandom, $urandom});
      send_command(CMD_WRITE, 4'd1, {$urandom, $urandom});
      send_command(CMD_READ, 4'd1, '0);
      write_capacity(11'd3);
      send_command(CMD_WRITE, 4'd2, {$urandom, $urandom});
      send_command(CMD_READ, 4'd2, '0);
      send_command(CMD_WRITE, 4'd3, {$urandom, $urandom});
      send_command(CMD_READ, 4'd3, '0);
      write_capacity(11'h7FF);
      send_command(CMD_WRITE, 4'd8, {$urandom, $urandom});
      write_capacity(11'd1024);
      send_command(CMD_READ, 4'd1, '0);
   endtask

   // One capacity setting, then random commands biased to fill or drain
   task automatic run_segment(logic [CAP_W-1:0] cap, int count);
      logic [CMD_W-1:0] cmd;
      logic [LEN_W-1:0] len;
      int               pick;
      write_capacity(cap);
      fill_mode = 1'b1;
      repeat (count) begin
         idle_pct = (random_sent < 317) ? 31 : (random_sent < 634) ? 76 : 0;
         pick = $urandom_range(99);
         if (fill_mode) begin
            cmd = (pick < 72) ? CMD_WRITE : (pick < 80) ? CMD_READ : (pick < 86) ? CMD_SKIP :
                  (pick < 92) ? CMD_PEEK : (pick < 94) ? CMD_CLEAR : CMD_UNUSED_LO;
         end else begin
            cmd = (pick < 15) ? CMD_WRITE : (pick < 50) ? CMD_READ : (pick < 72) ? CMD_SKIP :
                  (pick < 92) ? CMD_PEEK : (pick < 94) ? CMD_CLEAR : CMD_UNUSED_LO;
         end
         if (cmd == CMD_UNUSED_LO) cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         pick = $urandom_range(99);
         len = (pick < 5) ? 4'd0 :
               (pick < 10) ? LEN_W'($urandom_range(FIFO_CHUNK + 1, 15)) :
               LEN_W'($urandom_range(1, FIFO_CHUNK));
         send_command(cmd, len, {$urandom, $urandom});
         random_sent++;
      end
   endtask

   task automatic test_random_traffic();
      run_segment(11'd1024, 300);
      run_segment(11'd1, 60);
      run_segment(11'd0, 40);
      run_segment(11'd16, 80);
      run_segment(11'd7, 80);
      run_segment(11'h7FF, 200);
      run_segment(CAP_W'($urandom_range(17, 1022)), 110);
      run_segment(11'd1023, 80);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_after_reset();
      test_zero_length();
      test_chunk_extremes();
      test_unknown_and_clear();
      test_capacity_limits();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
